/* design/hce_pkg.sv */
package hce_pkg;

  localparam int unsigned MAX_BLOCK = 4;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned KEY_W     = 20;
  localparam int unsigned SIZE_W    = 3;
  localparam int unsigned COL_W     = 2;
  localparam int unsigned REG_W     = 3;
  localparam int unsigned SUM_W     = 12;  // 4 * 31 * 31 fits

  localparam logic [LETTER_W-1:0] PAD_CODE = LETTER_W'(8'd88 - 8'd65);  // 'X'

  typedef enum logic [REG_W-1:0] {
    REG_BLOCK_SIZE = 3'd0,
    REG_KEY_ROW_0  = 3'd1,
    REG_KEY_ROW_1  = 3'd2,
    REG_KEY_ROW_2  = 3'd3,
    REG_KEY_ROW_3  = 3'd4
  } reg_idx_e;

  typedef logic [MAX_BLOCK-1:0][KEY_W-1:0]    key_mat_t;
  typedef logic [MAX_BLOCK-1:0][LETTER_W-1:0] letters_t;

  // one complete (possibly padded) block waiting to be encoded
  typedef struct packed {
    letters_t          letters;
    logic [SIZE_W-1:0] size;
    logic              last;
  } block_t;

  // block size register clamped to 1..MAX_BLOCK
  function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] bs);
    logic [SIZE_W-1:0] n;
    n = bs;
    if (bs == '0) n = SIZE_W'(1);
    else if (bs > SIZE_W'(MAX_BLOCK)) n = SIZE_W'(MAX_BLOCK);
    return n;
  endfunction

endpackage

/* design/hce_if.sv */
interface hce_in_if;
  logic                         valid;
  logic                         ready;
  logic [hce_pkg::LETTER_W-1:0] plain_letter;
  logic                         message_end;

  modport source (output valid, output plain_letter, output message_end, input ready);
  modport sink   (input valid, input plain_letter, input message_end, output ready);
endinterface

interface hce_out_if;
  logic                         valid;
  logic                         ready;
  logic [hce_pkg::LETTER_W-1:0] cipher_letter;
  logic                         block_last;
  logic                         message_last;

  modport source (output valid, output cipher_letter, output block_last,
                  output message_last, input ready);
  modport sink   (input valid, input cipher_letter, input block_last,
                  input message_last, output ready);
endinterface

interface hce_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [hce_pkg::REG_W-1:0] reg_index;
  logic [hce_pkg::KEY_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* design/hce_front.sv */
module hce_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  hce_in_if.sink                  in_i,
  input  logic [hce_pkg::SIZE_W-1:0] size_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output hce_pkg::block_t         push_data_o
);
  import hce_pkg::*;

  letters_t         held_letters_q;
  logic [COL_W-1:0] held_count_q, held_count_d;
  logic [SIZE_W-1:0] fill;
  logic             accept, done;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign fill       = SIZE_W'(held_count_q) + SIZE_W'(1);
  assign done       = (fill >= size_i) || in_i.message_end;
  assign push_o     = accept && done;

  always_comb begin
    push_data_o.size = size_i;
    push_data_o.last = in_i.message_end;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (COL_W'(j) < held_count_q) push_data_o.letters[j] = held_letters_q[j];
      else if (COL_W'(j) == held_count_q) push_data_o.letters[j] = in_i.plain_letter;
      else push_data_o.letters[j] = PAD_CODE;
    end
  end

  always_comb begin
    held_count_d = held_count_q;
    if (accept) held_count_d = done ? '0 : fill[COL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
    end else begin
      held_count_q <= held_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) held_letters_q[held_count_q] <= in_i.plain_letter;
  end

endmodule

/* design/hce_queue.sv */
module hce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hce_pkg::block_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output hce_pkg::block_t head_o
);
  import hce_pkg::*;

  localparam int unsigned DEPTH = 2;

  block_t     entries_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    else if (do_pop && !do_push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* design/hce_back.sv */
module hce_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hce_pkg::key_mat_t keys_i,
  input  logic              head_valid_i,
  input  hce_pkg::block_t   head_i,
  output logic              pop_o,
  hce_out_if.source         out_o
);
  import hce_pkg::*;

  logic [COL_W-1:0]    col_q, col_d;
  logic                take, last_col;
  logic [SUM_W-1:0]    dot;
  logic                s1_valid_q, s1_ready, s2_ready;
  logic [SUM_W-1:0]    s1_sum_q;
  logic                s1_blast_q, s1_mlast_q;
  logic                out_valid_q;
  logic [LETTER_W-1:0] out_letter_q;
  logic                out_blast_q, out_mlast_q;
  logic [20:0]         recip_prod;
  logic [7:0]          quot;
  logic [SUM_W-1:0]    rem_raw;
  logic [LETTER_W:0]   rem;
  logic [LETTER_W-1:0] letter_mod;

  assign s2_ready = !out_valid_q || out_o.ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign take     = head_valid_i && s1_ready;
  assign last_col = (SIZE_W'(col_q) + SIZE_W'(1) == head_i.size);
  assign pop_o    = take && last_col;

  // one column of the row-vector times key product
  always_comb begin
    dot = '0;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (SIZE_W'(j) < head_i.size)
        dot = dot + SUM_W'(head_i.letters[j] * keys_i[j][LETTER_W*col_q +: LETTER_W]);
    end
  end

  always_comb begin
    col_d = col_q;
    if (take) col_d = last_col ? '0 : col_q + COL_W'(1);
  end

  // mod 26: 315/8192 underestimates 1/26 by less than one unit over the sum range,
  // so at most one correction
  always_comb begin
    recip_prod = 21'(s1_sum_q) * 21'd315;
    quot       = recip_prod[20:13];
    rem_raw    = s1_sum_q - SUM_W'(12'(quot) * 12'd26);
    rem        = rem_raw[LETTER_W:0];
    letter_mod = (rem >= 6'd26) ? LETTER_W'(rem - 6'd26) : rem[LETTER_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      if (s1_ready) s1_valid_q <= head_valid_i;
      if (s2_ready) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_sum_q   <= dot;
      s1_blast_q <= last_col;
      s1_mlast_q <= last_col && head_i.last;
    end
    if (s1_valid_q && s2_ready) begin
      out_letter_q <= letter_mod;
      out_blast_q  <= s1_blast_q;
      out_mlast_q  <= s1_mlast_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cipher_letter = out_letter_q;
  assign out_o.block_last    = out_blast_q;
  assign out_o.message_last  = out_mlast_q;

endmodule

/* design/hill_cipher_encoder_unit.sv */
// Channel | Dir | Beat payload                               | Accepted when
// cfg_i   | in  | reg_index, wdata                           | valid && ready
// in_i    | in  | plain_letter, message_end                  | valid && ready
// out_o   | out | cipher_letter, block_last, message_last    | valid && ready
//
// One plaintext letter per cycle in while the queue has room, one cipher letter
// per cycle out while out_o is ready. A block leaves as block_size beats,
// passing the queue, column product/sum and mod-26 output registers in order.
// The two-entry block queue decouples gathering from encoding; in_i stalls only
// when it is full. Reset: block size 3, identity key, no partial block held.
module hill_cipher_encoder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  hce_cfg_if.sink   cfg_i,
  hce_in_if.sink    in_i,
  hce_out_if.source out_o
);
  import hce_pkg::*;

  logic [SIZE_W-1:0] block_size_q;
  key_mat_t          keys_q;
  logic [SIZE_W-1:0] size_act;
  logic              q_full, q_valid, push, pop;
  block_t            push_data, head;

  assign cfg_i.ready = 1'b1;
  assign size_act    = active_size(block_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= SIZE_W'(3);
      keys_q[0]    <= KEY_W'(1);
      keys_q[1]    <= KEY_W'(32);
      keys_q[2]    <= KEY_W'(1024);
      keys_q[3]    <= KEY_W'(32768);
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.reg_index))
        REG_BLOCK_SIZE: block_size_q <= cfg_i.wdata[SIZE_W-1:0];
        REG_KEY_ROW_0:  keys_q[0] <= cfg_i.wdata;
        REG_KEY_ROW_1:  keys_q[1] <= cfg_i.wdata;
        REG_KEY_ROW_2:  keys_q[2] <= cfg_i.wdata;
        REG_KEY_ROW_3:  keys_q[3] <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  hce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .size_i      (size_act),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  hce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .keys_i       (keys_q),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

/* design/hce_checker.sv */
module hce_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [hce_pkg::LETTER_W-1:0] cipher_letter_i,
  input logic                         block_last_i,
  input logic                         message_last_i
);
  import hce_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cipher_letter_i)
      && $stable(block_last_i) && $stable(message_last_i))
    else $error("stalled output beat changed");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cipher_letter_i < LETTER_W'(26))
    else $error("cipher letter not reduced mod 26");

  a_msg_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && message_last_i |-> block_last_i)
    else $error("message end not on a block boundary");

  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid straight out of reset");

endmodule

bind hill_cipher_encoder_unit hce_checker u_hce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cipher_letter_i (out_o.cipher_letter),
  .block_last_i    (out_o.block_last),
  .message_last_i  (out_o.message_last)
);
